[sv/sdd_pkg.sv]
// ----------------------------------------------------------------------------
// sdd_pkg
// Shared types and codes of the sparse depth densifier: transaction payloads,
// command codes and the command and status groups between control and datapath.
// ----------------------------------------------------------------------------
package sdd_pkg;

    // Command codes of an input transaction.
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_QUERY = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Configuration register.
    localparam int RADIUS_W = 4;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 4'd4;

    // Depth field width.
    localparam int DEPTH_W = 16;

    typedef struct packed {
        logic [1:0]  command;
        logic [17:0] point_col;
        logic [17:0] point_row;
        logic [15:0] point_depth;
        logic [11:0] query_row;
        logic [11:0] query_col;
    } t_in;

    typedef struct packed {
        logic [15:0] estimated_depth;
        logic        had_neighbors;
    } t_out;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic decode;
        logic clr_step;
        logic div_start;
        logic div_final;
        logic sqrt_start;
        logic mem_write;
        logic q_step;
        logic out_load;
        logic out_zero;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] command;
        logic       outside;
        logic       sq_zero;
        logic       border;
        logic       clr_last;
        logic       issue_last;
        logic       pipe_busy;
        logic       div_busy;
        logic       sqrt_busy;
        logic       den_zero;
        logic       out_busy;
    } t_sts;

endpackage

[sv/sdd_div.sv]
// ----------------------------------------------------------------------------
// sdd_div
// Restoring divider, one quotient bit per cycle, quotient rounded toward zero.
// ----------------------------------------------------------------------------
module sdd_div #(
    parameter int NW  = 42,
    parameter int DVW = 26
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [NW-1:0]  i_dividend,
    input  logic [DVW-1:0] i_divisor,
    output logic           o_busy,
    output logic [NW-1:0]  o_quot
);

    localparam int CNTW = $clog2(NW + 1);

    logic            r_busy;
    logic [CNTW-1:0] r_cnt;
    logic [DVW-1:0]  r_rem;
    logic [DVW-1:0]  r_dvs;
    logic [NW-1:0]   r_q;
    logic [DVW:0]    trial;
    logic            qbit;

    // One trial subtraction per cycle.
    always_comb begin
        trial = {r_rem, r_q[NW-1]};
        qbit  = (trial >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNTW'(NW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNTW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // The dividend shifts out of the top as the quotient shifts in below.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_q   <= i_dividend;
        end else if (r_busy) begin
            r_rem <= qbit ? DVW'(trial - {1'b0, r_dvs}) : trial[DVW-1:0];
            r_q   <= {r_q[NW-2:0], qbit};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;

endmodule

[sv/sdd_isqrt.sv]
// ----------------------------------------------------------------------------
// sdd_isqrt
// Integer square root, rounded down, one result bit per cycle.
// ----------------------------------------------------------------------------
module sdd_isqrt #(
    parameter int IW = 30
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [IW-1:0]   i_value,
    output logic            o_busy,
    output logic [IW/2-1:0] o_root
);

    localparam int RW   = IW / 2;
    localparam int CNTW = $clog2(RW + 1);

    logic            r_busy;
    logic [CNTW-1:0] r_cnt;
    logic [IW-1:0]   r_val;
    logic [RW-1:0]   r_rem;
    logic [RW-1:0]   r_root;
    logic [RW+1:0]   rem2;
    logic [RW+1:0]   trial;
    logic            hit;

    // Bring down two bits and try the next root bit.
    always_comb begin
        rem2  = {r_rem, r_val[IW-1:IW-2]};
        trial = {r_root, 2'b01};
        hit   = (rem2 >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNTW'(RW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNTW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_value;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_val  <= {r_val[IW-3:0], 2'b00};
            r_rem  <= hit ? RW'(rem2 - trial) : rem2[RW-1:0];
            r_root <= {r_root[RW-2:0], hit};
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

endmodule

[sv/sdd_datapath.sv]
// ----------------------------------------------------------------------------
// sdd_datapath
// Pixel store, point rounding, weight computation, window scan, accumulation,
// final division and the output register.
// ----------------------------------------------------------------------------
module sdd_datapath #(
    parameter int IMG_ROWS   = 375,
    parameter int IMG_COLS   = 1242,
    parameter int MAX_RADIUS = 8,
    parameter int FRAC_BITS  = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sdd_pkg::t_cmd                 i_cmd,
    output sdd_pkg::t_sts                 o_sts,
    input  sdd_pkg::t_in                  i_in,
    input  logic                          i_cfg_we,
    input  logic [sdd_pkg::RADIUS_W-1:0]  i_cfg_wdata,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output sdd_pkg::t_out                 o_out
);
    import sdd_pkg::*;

    localparam int NPIX   = IMG_ROWS * IMG_COLS;
    localparam int AW     = $clog2(NPIX);
    localparam int F      = FRAC_BITS;
    localparam int PXW    = 19 - F;
    localparam int SQW    = 2 * F;
    localparam int WW     = F + 9;
    localparam int CW     = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
    localparam int DVW    = WW + CW;
    localparam int NW     = DEPTH_W + WW + CW;
    localparam int SIW    = 2 * F + 18;
    localparam int MEMW   = WW + DEPTH_W;
    localparam int WCW    = $clog2(2 * MAX_RADIUS + 1);
    localparam int TOPSH  = 2 * (F + 8);

    // Captured transaction.
    logic [1:0]         r_command;
    logic [17:0]        r_col;
    logic [17:0]        r_row;
    logic [DEPTH_W-1:0] r_depth;
    logic [11:0]        r_qr;
    logic [11:0]        r_qc;
    logic [RADIUS_W-1:0] r_radius;

    // Rounding and offset of a point.
    logic [18:0]    col_sum, row_sum, col_base, row_base, col_ext, row_ext;
    logic [PXW-1:0] pc, pr;
    logic [F-1:0]   oc, orr;
    logic [SQW-1:0] sq;
    logic           outside;
    logic [4:0]     rad;
    logic [WCW-1:0] span;
    logic           border;

    // Store and scan.
    logic [MEMW-1:0] r_mem [NPIX];
    logic [MEMW-1:0] r_rdata;
    logic [AW-1:0]   r_addr;
    logic [AW-1:0]   r_raddr;
    logic [AW-1:0]   r_clr_addr;
    logic [WCW-1:0]  r_wr, r_wc;
    logic            r_sqz;
    logic            r_v1, r_v2;
    logic [DEPTH_W+WW-1:0] r_prod;
    logic [WW-1:0]   r_pw;
    logic [NW-1:0]   r_num;
    logic [DVW-1:0]  r_den;
    logic            r_out_valid;
    t_out            r_out;

    logic [NW-1:0]   div_dividend;
    logic [DVW-1:0]  div_divisor;
    logic            div_busy;
    logic [NW-1:0]   div_quot;
    logic            sqrt_busy;
    logic [WW-1:0]   sqrt_root;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
        end else if (i_cfg_we) begin
            r_radius <= i_cfg_wdata;
        end
    end

    // Capture of the accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_command <= CMD_LOAD;
        end else if (i_cmd.capture) begin
            r_command <= i_in.command;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_col   <= i_in.point_col;
            r_row   <= i_in.point_row;
            r_depth <= i_in.point_depth;
            r_qr    <= i_in.query_row;
            r_qc    <= i_in.query_col;
        end
    end

    // Round half up to a pixel and take the offset to its centre.
    always_comb begin
        col_ext  = {1'b0, r_col};
        row_ext  = {1'b0, r_row};
        col_sum  = col_ext + 19'(1 << (F - 1));
        row_sum  = row_ext + 19'(1 << (F - 1));
        pc       = col_sum[18:F];
        pr       = row_sum[18:F];
        col_base = {pc, {F{1'b0}}};
        row_base = {pr, {F{1'b0}}};
        oc       = (col_ext >= col_base) ? F'(col_ext - col_base) : F'(col_base - col_ext);
        orr      = (row_ext >= row_base) ? F'(row_ext - row_base) : F'(row_base - row_ext);
        sq       = SQW'(oc * oc) + SQW'(orr * orr);
        outside  = (32'(pc) >= IMG_COLS) || (32'(pr) >= IMG_ROWS);
    end

    // Window radius, clamped, and the border test of a query.
    always_comb begin
        rad    = ({1'b0, r_radius} > 5'(MAX_RADIUS)) ? 5'(MAX_RADIUS) : {1'b0, r_radius};
        span   = WCW'({rad, 1'b0});
        border = (r_qr < 12'(rad)) || ((13'(r_qr) + 13'(rad)) >= 13'(IMG_ROWS)) ||
                 (r_qc < 12'(rad)) || ((13'(r_qc) + 13'(rad)) >= 13'(IMG_COLS));
    end

    // Load address, scan start address and scan counters.
    always_ff @(posedge i_clk) begin
        if (i_cmd.decode) begin
            r_addr  <= AW'(pr) * AW'(IMG_COLS) + AW'(pc);
            r_raddr <= AW'(r_qr - 12'(rad)) * AW'(IMG_COLS) + AW'(r_qc - 12'(rad));
            r_wr    <= '0;
            r_wc    <= '0;
            r_sqz   <= (sq == '0);
        end else if (i_cmd.q_step) begin
            if (r_wc == span) begin
                r_wc    <= '0;
                r_wr    <= r_wr + 1'b1;
                r_raddr <= r_raddr + AW'(IMG_COLS) - AW'(span);
            end else begin
                r_wc    <= r_wc + 1'b1;
                r_raddr <= r_raddr + 1'b1;
            end
        end
    end

    // Clearing pass counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= (r_clr_addr == AW'(NPIX - 1)) ? '0 : r_clr_addr + 1'b1;
        end
    end

    // Pixel store: weight and depth for each pixel, zero weight when empty.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_cmd.mem_write) begin
            r_mem[r_addr] <= {(r_sqz ? WW'(0) : sqrt_root), r_depth};
        end
        if (i_cmd.q_step) begin
            r_rdata <= r_mem[r_raddr];
        end
    end

    // Read, multiply and accumulate pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.q_step;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_prod <= r_rdata[DEPTH_W-1:0] * r_rdata[MEMW-1:DEPTH_W];
            r_pw   <= r_rdata[MEMW-1:DEPTH_W];
        end
        if (i_cmd.decode) begin
            r_num <= '0;
            r_den <= '0;
        end else if (r_v2) begin
            r_num <= r_num + NW'(r_prod);
            r_den <= r_den + DVW'(r_pw);
        end
    end

    // Shared divider: weight of a load, or the final mean of a query.
    always_comb begin
        div_dividend = i_cmd.div_final ? r_num : (NW'(1) << TOPSH);
        div_divisor  = i_cmd.div_final ? r_den : DVW'(sq);
    end

    sdd_div #(
        .NW  (NW),
        .DVW (DVW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_quot     (div_quot)
    );

    sdd_isqrt #(
        .IW (SIW)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sqrt_start),
        .i_value (SIW'(div_quot)),
        .o_busy  (sqrt_busy),
        .o_root  (sqrt_root)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.estimated_depth <= i_cmd.out_zero ? 16'd0 : div_quot[15:0];
            r_out.had_neighbors   <= !i_cmd.out_zero;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Status towards the controller.
    always_comb begin
        o_sts.command    = r_command;
        o_sts.outside    = outside;
        o_sts.sq_zero    = (sq == '0);
        o_sts.border     = border;
        o_sts.clr_last   = (r_clr_addr == AW'(NPIX - 1));
        o_sts.issue_last = (r_wr == span) && (r_wc == span);
        o_sts.pipe_busy  = r_v1 || r_v2;
        o_sts.div_busy   = div_busy;
        o_sts.sqrt_busy  = sqrt_busy;
        o_sts.den_zero   = (r_den == '0);
        o_sts.out_busy   = r_out_valid && !i_out_ready;
    end

endmodule

[sv/sdd_ctrl.sv]
// ----------------------------------------------------------------------------
// sdd_ctrl
// Controller: sequences clearing, loads and queries over the datapath.
// ----------------------------------------------------------------------------
module sdd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  sdd_pkg::t_sts i_sts,
    output sdd_pkg::t_cmd o_cmd
);
    import sdd_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_LDIV,
        S_LSQRT,
        S_LWRITE,
        S_QRUN,
        S_QDRAIN,
        S_QDIV,
        S_RESULT
    } t_state;

    t_state r_state, n_state;
    logic   r_zero, n_zero;

    // Next state.
    always_comb begin
        n_state = r_state;
        n_zero  = r_zero;
        unique case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                unique case (i_sts.command)
                    CMD_LOAD: begin
                        if (i_sts.outside)      n_state = S_IDLE;
                        else if (i_sts.sq_zero) n_state = S_LWRITE;
                        else                    n_state = S_LDIV;
                    end
                    CMD_QUERY: begin
                        if (i_sts.border) begin
                            n_state = S_RESULT;
                            n_zero  = 1'b1;
                        end else begin
                            n_state = S_QRUN;
                        end
                    end
                    CMD_CLEAR: n_state = S_CLEAR;
                    default:   n_state = S_IDLE;
                endcase
            end
            S_LDIV: begin
                if (!i_sts.div_busy) n_state = S_LSQRT;
            end
            S_LSQRT: begin
                if (!i_sts.sqrt_busy) n_state = S_LWRITE;
            end
            S_LWRITE: n_state = S_IDLE;
            S_QRUN: begin
                if (i_sts.issue_last) n_state = S_QDRAIN;
            end
            S_QDRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_zero  = i_sts.den_zero;
                    n_state = i_sts.den_zero ? S_RESULT : S_QDIV;
                end
            end
            S_QDIV: begin
                if (!i_sts.div_busy) n_state = S_RESULT;
            end
            S_RESULT: begin
                if (!i_sts.out_busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_zero  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_zero  <= n_zero;
        end
    end

    // Commands to the datapath.
    always_comb begin
        o_in_ready       = (r_state == S_IDLE);
        o_cmd.capture    = (r_state == S_IDLE) && i_in_valid;
        o_cmd.decode     = (r_state == S_DECODE);
        o_cmd.clr_step   = (r_state == S_CLEAR);
        o_cmd.div_start  = ((r_state == S_DECODE) && (i_sts.command == CMD_LOAD) &&
                            !i_sts.outside && !i_sts.sq_zero) ||
                           ((r_state == S_QDRAIN) && !i_sts.pipe_busy && !i_sts.den_zero);
        o_cmd.div_final  = (r_state == S_QDRAIN);
        o_cmd.sqrt_start = (r_state == S_LDIV) && !i_sts.div_busy;
        o_cmd.mem_write  = (r_state == S_LWRITE);
        o_cmd.q_step     = (r_state == S_QRUN);
        o_cmd.out_load   = (r_state == S_RESULT) && !i_sts.out_busy;
        o_cmd.out_zero   = r_zero;
    end

    // A result is only loaded into a free output register.
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> !i_sts.out_busy)
        else $error("result loaded over a pending one");

    // The divider is never restarted while it runs.
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |-> !i_sts.div_busy)
        else $error("divider restarted while busy");

    // No new transaction is taken while the store is written.
    a_write_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.mem_write || o_cmd.clr_step) |-> !o_in_ready)
        else $error("input accepted during a store write");

    // A window scan is followed by the drain of the read pipeline.
    a_scan_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.q_step && i_sts.issue_last) |=> (r_state == S_QDRAIN))
        else $error("window scan did not drain");

endmodule

[sv/sparse_depth_idw_densifier.sv]
// ----------------------------------------------------------------------------
// sparse_depth_idw_densifier
// Load: decode, then division and square root for the weight, then the store write.
// Query: (2R+1)^2 store reads, one per cycle, then drain, division and output.
// Clear and reset: one store entry per cycle over the whole store, no input.
// One transaction is processed at a time; the single store port sets the query rate.
// Reset is synchronous, active low, and starts the clearing pass.
// ----------------------------------------------------------------------------
module sparse_depth_idw_densifier #(
    parameter int IMG_ROWS   = 375,
    parameter int IMG_COLS   = 1242,
    parameter int MAX_RADIUS = 8,
    parameter int FRAC_BITS  = 6
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  sdd_pkg::t_in                 i_in,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output sdd_pkg::t_out                o_out,
    input  logic                         i_cfg_we,
    input  logic [sdd_pkg::RADIUS_W-1:0] i_cfg_wdata
);
    import sdd_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Controller.
    sdd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath.
    sdd_datapath #(
        .IMG_ROWS   (IMG_ROWS),
        .IMG_COLS   (IMG_COLS),
        .MAX_RADIUS (MAX_RADIUS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

[verif/tb_sparse_depth_idw_densifier.sv]
// ----------------------------------------------------------------------------
// tb_sparse_depth_idw_densifier
// Self-checking bench for the sparse depth densifier. A short table of
// directed transactions is followed by random loads and queries, mostly clustered
// in one small patch of the image, under several window radii. Every query
// result is compared against a behavioural model of the pixel store.
// ----------------------------------------------------------------------------
module tb_sparse_depth_idw_densifier;
    timeunit 1ns;
    timeprecision 1ps;
    import sdd_pkg::*;

    localparam int ROWS      = 375;
    localparam int COLS      = 1242;
    localparam int RAD_LIMIT = 8;
    localparam int FRAC      = 6;
    localparam int SETTLE    = 700;
    localparam logic [1:0] CMD_SPARE = 2'd3;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    t_in                 in_item = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    t_out                out_item;
    logic                cfg_we = 1'b0;
    logic [RADIUS_W-1:0] cfg_wdata = '0;

    // Model state: squared offset and depth per occupied pixel, and the radius.
    int unsigned         offset_sq_of[int];
    logic [15:0]         depth_of[int];
    logic [RADIUS_W-1:0] radius_reg = RADIUS_RESET;

    t_out expected_depths[$];
    bit   failed = 1'b0;
    bit   idle_on = 1'b1;
    bit   hold_req = 1'b0;
    bit   hold_done = 1'b0;

    sparse_depth_idw_densifier i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // Integer square root, one result bit per iteration.
    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v) begin
                root = trial;
            end
        end
        return root;
    endfunction

    // Splits a sub-pixel coordinate into its rounded pixel and absolute offset.
    function automatic void split(input logic [17:0] c, output int unsigned pix,
                                  output int unsigned off);
        int unsigned base;
        pix  = (int'(c) + (1 << (FRAC - 1))) >> FRAC;
        base = pix << FRAC;
        off  = (c >= base) ? c - base : base - c;
    endfunction

    // Applies one transaction to the store model; returns 1 when a result follows.
    function automatic bit densify(input t_in it, output t_out res);
        int unsigned pc, pr, oc, orow, rad, key;
        longint unsigned num, den, w;
        res = '0;
        case (it.command)
            CMD_LOAD: begin
                split(it.point_col, pc, oc);
                split(it.point_row, pr, orow);
                if (pc < COLS && pr < ROWS) begin
                    key = pr * COLS + pc;
                    offset_sq_of[key] = oc * oc + orow * orow;
                    depth_of[key] = it.point_depth;
                end
                return 1'b0;
            end
            CMD_CLEAR: begin
                offset_sq_of.delete();
                depth_of.delete();
                return 1'b0;
            end
            CMD_QUERY: begin
                rad = (radius_reg > RAD_LIMIT) ? RAD_LIMIT : radius_reg;
                if (it.query_row < rad || it.query_row + rad >= ROWS ||
                    it.query_col < rad || it.query_col + rad >= COLS) begin
                    return 1'b1;
                end
                num = 0;
                den = 0;
                for (int r = it.query_row - rad; r <= it.query_row + rad; r++) begin
                    for (int c = it.query_col - rad; c <= it.query_col + rad; c++) begin
                        key = r * COLS + c;
                        if (offset_sq_of.exists(key) && offset_sq_of[key] != 0) begin
                            w = isqrt((64'd1 << (2 * (FRAC + 8))) / offset_sq_of[key]);
                            num += depth_of[key] * w;
                            den += w;
                        end
                    end
                end
                if (den != 0) begin
                    res.estimated_depth = 16'(num / den);
                    res.had_neighbors = 1'b1;
                end
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // Offers one transaction, with an optional idle burst first, and records
    // the expected result once it is accepted.
    task automatic offer(input t_in it, input bit typed, input t_out typed_res);
        t_out res;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
        if (densify(it, res)) begin
            if (typed) begin
                res = typed_res;
            end
            expected_depths = {expected_depths, res};
        end
    endtask

    // Radius write once all queries have answered and the block has gone quiet.
    task automatic set_radius(input logic [RADIUS_W-1:0] value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_depths.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we     <= 1'b0;
        radius_reg = value;
    endtask

    // Random transaction: mostly loads and queries around one busy patch.
    function automatic t_in random_item();
        t_in it;
        int unsigned pick;
        it = '0;
        it.point_col   = 18'($urandom);
        it.point_row   = 18'($urandom);
        it.point_depth = 16'($urandom);
        it.query_row   = 12'($urandom);
        it.query_col   = 12'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            it.command = CMD_LOAD;
            if (pick < 44) begin
                it.point_col = 18'($urandom_range(20 << FRAC, 60 << FRAC));
                it.point_row = 18'($urandom_range(20 << FRAC, 60 << FRAC));
            end
        end else if (pick < 97) begin
            it.command = CMD_QUERY;
            if (pick < 92) begin
                it.query_row = 12'($urandom_range(15, 65));
                it.query_col = 12'($urandom_range(15, 65));
            end
        end else begin
            it.command = CMD_SPARE;
        end
        return it;
    endfunction

    // Receiver: random stalls, and one long hold-off when asked.
    initial begin
        forever begin
            if (hold_req && !hold_done) begin
                out_ready <= 1'b0;
                repeat (2000) @(posedge clk);
                hold_done = 1'b1;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Each result transaction is compared with the oldest expectation.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (expected_depths.size() == 0) begin
                $display("%0t: unexpected result depth=%h nb=%b", $time,
                         out_item.estimated_depth, out_item.had_neighbors);
                failed = 1'b1;
            end else begin
                if (out_item.estimated_depth !== expected_depths[0].estimated_depth) begin
                    $display("%0t: depth expected %h actual %h", $time,
                             expected_depths[0].estimated_depth, out_item.estimated_depth);
                    failed = 1'b1;
                end
                if (out_item.had_neighbors !== expected_depths[0].had_neighbors) begin
                    $display("%0t: neighbour flag expected %b actual %b", $time,
                             expected_depths[0].had_neighbors, out_item.had_neighbors);
                    failed = 1'b1;
                end
                void'(expected_depths.pop_front());
            end
        end
    end

    typedef struct {
        t_in  it;
        bit   typed;
        t_out res;
    } t_row;

    function automatic t_row row(logic [1:0] cmd, int col, int rw, int dep,
                                 int qr, int qc, bit typed = 0, int exp_dep = 0,
                                 bit exp_nb = 0);
        t_row r;
        r.it = '0;
        r.it.command = cmd;
        r.it.point_col = 18'(col);
        r.it.point_row = 18'(rw);
        r.it.point_depth = 16'(dep);
        r.it.query_row = 12'(qr);
        r.it.query_col = 12'(qc);
        r.typed = typed;
        r.res.estimated_depth = 16'(exp_dep);
        r.res.had_neighbors = exp_nb;
        return r;
    endfunction

    // Stimulus.
    initial begin
        t_row rows[$];
        logic [RADIUS_W-1:0] radii[5];

        radii = '{4'd0, 4'd8, 4'd15, 4'd1, 4'd5};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table at the reset radius of four.
        rows = {rows, row(CMD_QUERY, 0, 0, 0, 100, 100, 1, 0, 0)};
        rows = {rows, row(CMD_QUERY, 0, 0, 0, 0, 0, 1, 0, 0)};
        rows = {rows, row(CMD_QUERY, 0, 0, 0, 4095, 4095, 1, 0, 0)};
        rows = {rows, row(CMD_LOAD, (100 << 6) + 5, (50 << 6) + 3, 16'hFFFF, 0, 0)};
        rows = {rows, row(CMD_LOAD, 18'h3FFFF, 18'h3FFFF, 16'h5555, 0, 0)};
        rows = {rows, row(CMD_LOAD, 0, 0, 0, 0, 0)};
        rows = {rows, row(CMD_LOAD, (101 << 6) + 32, (50 << 6) - 31, 16'h1234, 0, 0)};
        rows = {rows, row(CMD_LOAD, (1241 << 6) + 31, (374 << 6) + 31, 16'h0800, 0, 0)};
        rows = {rows, row(CMD_QUERY, 0, 0, 0, 50, 100)};
        rows = {rows, row(CMD_LOAD, (100 << 6) - 20, (50 << 6) + 17, 16'h0100, 0, 0)};
        rows = {rows, row(CMD_QUERY, 0, 0, 0, 50, 100)};
        rows = {rows, row(CMD_LOAD, 100 << 6, 50 << 6, 16'h7777, 0, 0)};
        rows = {rows, row(CMD_QUERY, 0, 0, 0, 50, 100)};
        rows = {rows, row(CMD_SPARE, 0, 0, 0, 50, 100)};
        rows = {rows, row(CMD_QUERY, 0, 0, 0, 50, 101)};
        rows = {rows, row(CMD_QUERY, 0, 0, 0, 4, 4)};
        rows = {rows, row(CMD_QUERY, 0, 0, 0, 370, 1237)};
        rows = {rows, row(CMD_QUERY, 0, 0, 0, 371, 1237, 1, 0, 0)};
        rows = {rows, row(CMD_CLEAR, 0, 0, 0, 0, 0)};
        rows = {rows, row(CMD_QUERY, 0, 0, 0, 50, 102, 1, 0, 0)};
        foreach (rows[i]) begin
            offer(rows[i].it, rows[i].typed, rows[i].res);
        end

        // Random phases, one per radius; the last one runs without idling.
        foreach (radii[p]) begin
            set_radius(radii[p]);
            if (p == 4) begin
                idle_on = 1'b0;
            end
            for (int n = 0; n < 106; n++) begin
                if (p == 1 && n == 30) begin
                    hold_req = 1'b1;
                end
                offer(random_item(), 1'b0, '0);
            end
        end
        in_valid <= 1'b0;

        while (expected_depths.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (!failed) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog: two clearing passes plus the slowest queries fit well inside.
    initial begin
        #50ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
